>>> src/gss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gss_pkg
// shared types, constants and byte classifiers for the gbk string sanitizer
// ----------------------------------------------------------------------------
package gss_pkg;

  localparam int COUNT_BITS = 16;
  localparam int CODE_BITS  = 16;
  localparam int CFG_IDX_BITS = 2;
  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_BITS = $clog2(Q_DEPTH);

  // register indexes of the configuration port
  localparam logic [CFG_IDX_BITS-1:0] REG_OUT_CAPACITY   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_DQUOTE_CODE    = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_BACKSLASH_CODE = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_SQUOTE_CODE    = 2'd3;

  localparam logic [COUNT_BITS-1:0] RST_OUT_CAPACITY   = 16'd65535;
  localparam logic [CODE_BITS-1:0]  RST_DQUOTE_CODE    = 16'hA3A2;
  localparam logic [CODE_BITS-1:0]  RST_BACKSLASH_CODE = 16'hA1A2;
  localparam logic [CODE_BITS-1:0]  RST_SQUOTE_CODE    = 16'hA1AF;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_TILDE  = 8'h7E;
  localparam logic [7:0] CH_NUL    = 8'h00;

  typedef struct packed {
    logic [COUNT_BITS-1:0] out_capacity;
    logic [CODE_BITS-1:0]  dquote_code;
    logic [CODE_BITS-1:0]  backslash_code;
    logic [CODE_BITS-1:0]  squote_code;
  } cfg_t;

  // one queued work record: up to three text bytes plus an optional terminator
  typedef struct packed {
    logic [1:0]      n_text;
    logic            term;
    logic [2:0][7:0] text;
  } rec_t;

  function automatic logic is_lead(input logic [7:0] b);
    return (b > 8'h80) && (b < 8'hFF);
  endfunction

  function automatic logic is_trail(input logic [7:0] b);
    return ((b > 8'h3F) && (b < 8'h7F)) || ((b > 8'h7F) && (b < 8'hFF));
  endfunction

endpackage

>>> src/gss_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gss_queue
// small fifo of work records between the front and back parts
// ----------------------------------------------------------------------------
module gss_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  gss_pkg::rec_t push_data,
  input  logic          pop,
  output gss_pkg::rec_t head,
  output logic          empty,
  output logic          full
);

  gss_pkg::rec_t                    entries [gss_pkg::Q_DEPTH];
  logic [gss_pkg::Q_PTR_BITS-1:0]   wr_ptr;
  logic [gss_pkg::Q_PTR_BITS-1:0]   rd_ptr;
  logic [gss_pkg::Q_PTR_BITS:0]     fill;

  assign empty = (fill == '0);
  assign full  = (fill == (gss_pkg::Q_PTR_BITS+1)'(gss_pkg::Q_DEPTH));
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

>>> src/gss_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gss_front
// accepts input bytes, tracks lead byte and output limit, builds records
// ----------------------------------------------------------------------------
module gss_front (
  input  logic          clk,
  input  logic          rst,
  input  gss_pkg::cfg_t cfg,
  input  logic          in_valid,
  input  logic [7:0]    in_byte,
  input  logic          in_last,
  output logic          in_stall,
  input  logic          q_full,
  output logic          push,
  output gss_pkg::rec_t rec
);

  logic                          lead_pending;
  logic [7:0]                    lead_value;
  logic [gss_pkg::COUNT_BITS-1:0] emitted_count;
  logic                          output_stopped;

  logic                          accept;
  logic                          full0;
  logic                          case_pair;
  logic                          case_space;
  logic                          fresh;
  logic [1:0]                    fk;
  logic [7:0]                    f0;
  logic [7:0]                    f1;
  logic [2:0][7:0]               raw;
  logic [1:0]                    k;
  logic [gss_pkg::COUNT_BITS-1:0] room;
  logic [1:0]                    n;
  logic [gss_pkg::COUNT_BITS:0]  count_sum;
  logic [gss_pkg::COUNT_BITS:0]  count_plus1;
  logic                          full_at_fresh;
  logic                          lead_pending_next;
  logic                          output_stopped_next;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    full0      = output_stopped || (emitted_count >= cfg.out_capacity);
    case_pair  = lead_pending && gss_pkg::is_trail(in_byte);
    case_space = lead_pending && !gss_pkg::is_trail(in_byte);
    fresh      = !lead_pending || case_space;

    // text of a byte handled as fresh input
    f0 = in_byte;
    f1 = gss_pkg::CH_SPACE;
    fk = 2'd1;
    if (gss_pkg::is_lead(in_byte)) begin
      fk = 2'd0;
    end else if ((in_byte < gss_pkg::CH_SPACE) || (in_byte > gss_pkg::CH_TILDE)) begin
      f0 = gss_pkg::CH_SPACE;
    end else if (in_byte == gss_pkg::CH_DQUOTE) begin
      f0 = cfg.dquote_code[15:8];
      f1 = cfg.dquote_code[7:0];
      fk = 2'd2;
    end else if (in_byte == gss_pkg::CH_BSLASH) begin
      f0 = cfg.backslash_code[15:8];
      f1 = cfg.backslash_code[7:0];
      fk = 2'd2;
    end else if (in_byte == gss_pkg::CH_SQUOTE) begin
      f0 = cfg.squote_code[15:8];
      f1 = cfg.squote_code[7:0];
      fk = 2'd2;
    end

    // candidate text before the limit is applied
    if (case_pair) begin
      raw = {gss_pkg::CH_SPACE, in_byte, lead_value};
      k   = 2'd2;
    end else if (case_space) begin
      raw = {f1, f0, gss_pkg::CH_SPACE};
      k   = fk + 2'd1;
    end else begin
      raw = {gss_pkg::CH_SPACE, f1, f0};
      k   = fk;
    end

    // clip to what is left below the limit
    room = cfg.out_capacity - emitted_count;
    if (full0) begin
      n = 2'd0;
    end else if (room < gss_pkg::COUNT_BITS'(k)) begin
      n = room[1:0];
    end else begin
      n = k;
    end

    count_sum   = {1'b0, emitted_count} + (gss_pkg::COUNT_BITS+1)'(n);
    count_plus1 = {1'b0, emitted_count} + 1'b1;
    output_stopped_next = output_stopped || (count_sum >= {1'b0, cfg.out_capacity});
    full_at_fresh = full0 || (case_space && (count_plus1 >= {1'b0, cfg.out_capacity}));
    lead_pending_next = !in_last && fresh && gss_pkg::is_lead(in_byte) && !full_at_fresh;

    rec.n_text = n;
    rec.term   = in_last;
    rec.text   = raw;
    push       = accept && ((n != 2'd0) || in_last);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lead_pending   <= 1'b0;
      lead_value     <= '0;
      emitted_count  <= '0;
      output_stopped <= 1'b0;
    end else if (accept) begin
      if (in_last) begin
        lead_pending   <= 1'b0;
        lead_value     <= '0;
        emitted_count  <= '0;
        output_stopped <= 1'b0;
      end else begin
        lead_pending   <= lead_pending_next;
        lead_value     <= in_byte;
        emitted_count  <= count_sum[gss_pkg::COUNT_BITS-1:0];
        output_stopped <= output_stopped_next;
      end
    end
  end

endmodule

>>> src/gss_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gss_back
// walks queued records and presents one result byte per transaction
// ----------------------------------------------------------------------------
module gss_back (
  input  logic          clk,
  input  logic          rst,
  input  gss_pkg::rec_t head,
  input  logic          q_empty,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    out_byte,
  output logic          run_last,
  output logic          string_end
);

  logic [1:0] idx;
  logic [2:0] total;
  logic       load;
  logic       slot_last;
  logic       slot_term;
  logic [7:0] slot_byte;

  always_comb begin
    total     = {1'b0, head.n_text} + {2'b00, head.term};
    load      = !q_empty && (!out_valid || !out_stall);
    slot_last = ({1'b0, idx} + 3'd1) == total;
    slot_term = head.term && (idx == head.n_text);
    case (idx)
      2'd0:    slot_byte = head.text[0];
      2'd1:    slot_byte = head.text[1];
      2'd2:    slot_byte = head.text[2];
      default: slot_byte = gss_pkg::CH_NUL;
    endcase
    if (slot_term) begin
      slot_byte = gss_pkg::CH_NUL;
    end
    pop = load && slot_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      idx       <= slot_last ? 2'd0 : idx + 2'd1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte   <= slot_byte;
      run_last   <= slot_last;
      string_end <= slot_term;
    end
  end

endmodule

>>> src/gbk_string_sanitizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbk_string_sanitizer
// cleans a gbk byte string one byte per transaction, with full-width quotes
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid/in_stall carry in_byte and in_last, one raw byte
//     per transaction; in_last marks the final byte of a string
//   output channel: out_valid/out_stall carry out_byte, run_last and
//     string_end; each input gives zero to four result transactions, run_last
//     flags the final one of an input, string_end flags the zero terminator
//   config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; ready is
//     always high, write only while no results are outstanding
// timing
//   the first result of an input passes through the record queue and the
//   back's output register; the front takes one byte per cycle unless the
//   queue is full; the back delivers one result per cycle while out_stall is
//   low (0 to 4 per input); a four-entry record queue sits between front and back
// reset
//   rst clears lead/limit state, empties the queue and loads default codes
// stall
//   out_stall holds the output register; the queue fills, and in_stall rises
//   once the queue is full
// ----------------------------------------------------------------------------
module gbk_string_sanitizer (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        run_last,
  output logic        string_end,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  gss_pkg::cfg_t cfg;
  gss_pkg::rec_t push_rec;
  gss_pkg::rec_t head_rec;
  logic          push;
  logic          pop;
  logic          q_empty;
  logic          q_full;

  assign cfg_ready = 1'b1;

  // configuration registers, written on a completed transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.out_capacity   <= gss_pkg::RST_OUT_CAPACITY;
      cfg.dquote_code    <= gss_pkg::RST_DQUOTE_CODE;
      cfg.backslash_code <= gss_pkg::RST_BACKSLASH_CODE;
      cfg.squote_code    <= gss_pkg::RST_SQUOTE_CODE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        gss_pkg::REG_OUT_CAPACITY:   cfg.out_capacity   <= cfg_data;
        gss_pkg::REG_DQUOTE_CODE:    cfg.dquote_code    <= cfg_data;
        gss_pkg::REG_BACKSLASH_CODE: cfg.backslash_code <= cfg_data;
        gss_pkg::REG_SQUOTE_CODE:    cfg.squote_code    <= cfg_data;
        default:                     cfg.out_capacity   <= cfg.out_capacity;
      endcase
    end
  end

  // front: classification, lead tracking and limit clipping
  gss_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .in_stall (in_stall),
    .q_full   (q_full),
    .push     (push),
    .rec      (push_rec)
  );

  // decoupling queue of records
  gss_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_rec),
    .pop       (pop),
    .head      (head_rec),
    .empty     (q_empty),
    .full      (q_full)
  );

  // back: serializes each record into result transactions
  gss_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head_rec),
    .q_empty    (q_empty),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .run_last   (run_last),
    .string_end (string_end)
  );

endmodule

>>> test/gss_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gss_checker
// watches the gbk sanitizer channels, predicts the cleaned byte stream and
// compares every output transaction with the oldest predicted result
// ----------------------------------------------------------------------------
module gss_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_byte,
  input  logic        run_last,
  input  logic        string_end,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_cnt,
  output int          outstanding
);

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       str_end;
  } clean_res_t;

  clean_res_t cleaned_q[$];

  gss_pkg::cfg_t regs;
  logic        lead_held;
  logic [7:0]  lead_byte;
  logic [16:0] text_cnt;
  logic        stopped;
  logic [7:0]  res_data [4];
  logic        res_end [4];
  int          nres;
  int          fails = 0;

  function automatic logic no_room();
    return stopped || (text_cnt >= {1'b0, regs.out_capacity});
  endfunction

  task automatic put_res(input logic [7:0] b, input logic term);
    if (nres < 4) begin
      res_data[nres] = b;
      res_end[nres] = term;
      nres++;
    end
  endtask

  // one text byte, counted against the capacity
  task automatic put_text(input logic [7:0] b);
    if (no_room()) begin
      stopped = 1'b1;
    end else begin
      put_res(b, 1'b0);
      text_cnt++;
      if (text_cnt >= {1'b0, regs.out_capacity}) stopped = 1'b1;
    end
  endtask

  task automatic put_code(input logic [15:0] code);
    put_text(code[15:8]);
    put_text(code[7:0]);
  endtask

  task automatic take_fresh(input logic [7:0] b, input logic fin);
    if (no_room()) begin
      stopped = 1'b1;
    end else if (b > 8'h80 && b < 8'hFF) begin
      if (!fin) begin
        lead_held = 1'b1;
        lead_byte = b;
      end
    end else if (b < gss_pkg::CH_SPACE || b > gss_pkg::CH_TILDE) begin
      put_text(gss_pkg::CH_SPACE);
    end else if (b == gss_pkg::CH_DQUOTE) begin
      put_code(regs.dquote_code);
    end else if (b == gss_pkg::CH_BSLASH) begin
      put_code(regs.backslash_code);
    end else if (b == gss_pkg::CH_SQUOTE) begin
      put_code(regs.squote_code);
    end else begin
      put_text(b);
    end
  endtask

  task automatic clear_string();
    lead_held = 1'b0;
    lead_byte = 8'h00;
    text_cnt = '0;
    stopped = 1'b0;
  endtask

  task automatic sanitize_byte(input logic [7:0] b, input logic fin);
    logic [7:0] held;
    clean_res_t r;
    nres = 0;
    if (lead_held) begin
      held = lead_byte;
      lead_held = 1'b0;
      lead_byte = 8'h00;
      if (no_room()) begin
        stopped = 1'b1;
      end else if ((b > 8'h3F && b < 8'h7F) || (b > 8'h7F && b < 8'hFF)) begin
        put_text(held);
        put_text(b);
      end else begin
        put_text(gss_pkg::CH_SPACE);
        take_fresh(b, fin);
      end
    end else begin
      take_fresh(b, fin);
    end
    if (fin) begin
      put_res(gss_pkg::CH_NUL, 1'b1);
      clear_string();
    end
    for (int i = 0; i < nres; i++) begin
      r.data = res_data[i];
      r.run_last = (i == nres - 1);
      r.str_end = res_end[i];
      cleaned_q.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    clean_res_t want;
    if (rst) begin
      regs.out_capacity = gss_pkg::RST_OUT_CAPACITY;
      regs.dquote_code = gss_pkg::RST_DQUOTE_CODE;
      regs.backslash_code = gss_pkg::RST_BACKSLASH_CODE;
      regs.squote_code = gss_pkg::RST_SQUOTE_CODE;
      clear_string();
      cleaned_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (cleaned_q.size() == 0) begin
          $display("%0t: unexpected result, actual out_byte %02h run_last %0b string_end %0b",
                   $time, out_byte, run_last, string_end);
          fails++;
        end else begin
          want = cleaned_q.pop_front();
          if (out_byte !== want.data) begin
            $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                     $time, want.data, out_byte);
            fails++;
          end
          if (run_last !== want.run_last) begin
            $display("%0t: run_last mismatch, expected %0b, actual %0b",
                     $time, want.run_last, run_last);
            fails++;
          end
          if (string_end !== want.str_end) begin
            $display("%0t: string_end mismatch, expected %0b, actual %0b",
                     $time, want.str_end, string_end);
            fails++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          gss_pkg::REG_OUT_CAPACITY:   regs.out_capacity = cfg_data;
          gss_pkg::REG_DQUOTE_CODE:    regs.dquote_code = cfg_data;
          gss_pkg::REG_BACKSLASH_CODE: regs.backslash_code = cfg_data;
          gss_pkg::REG_SQUOTE_CODE:    regs.squote_code = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) sanitize_byte(in_byte, in_last);
    end
    outstanding <= cleaned_q.size();
    fail_cnt <= fails;
  end

endmodule

>>> test/tb_gbk_string_sanitizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gbk_string_sanitizer
// drives byte strings into the gbk sanitizer under several register settings
// and idle/stall mixes; the checker beside the dut predicts and compares
// ----------------------------------------------------------------------------
module tb_gbk_string_sanitizer;

  // cycles left for the pipeline to settle when no result is outstanding
  localparam int SETTLE_CYCLES = 8;
  // cycles without any accepted transaction before the run is declared hung
  localparam int HANG_LIMIT = 2000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = 8'h00;
  logic        in_last = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;
  logic        run_last;
  logic        string_end;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = gss_pkg::REG_OUT_CAPACITY;
  logic [15:0] cfg_data = 16'h0000;

  int fail_cnt;
  int outstanding;
  int gap_pct = 0;     // chance per cycle that the sender idles
  int stall_pct = 0;   // chance per cycle that the receiver stalls
  int items_sent = 0;
  int quiet_cycles = 0;

  always #4 clk = ~clk;

  gbk_string_sanitizer dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_byte(in_byte), .in_last(in_last),
    .out_valid(out_valid), .out_stall(out_stall), .out_byte(out_byte),
    .run_last(run_last), .string_end(string_end),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  gss_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_byte(in_byte), .in_last(in_last),
    .out_valid(out_valid), .out_stall(out_stall), .out_byte(out_byte),
    .run_last(run_last), .string_end(string_end),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .fail_cnt(fail_cnt), .outstanding(outstanding)
  );

  // receiver side: random stall, independent of out_valid
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < stall_pct);
  end

  // hang detection: any accepted transaction on any channel restarts the count
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)
        || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HANG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, HANG_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one input transaction; valid is decided before it is raised and held
  // until accepted, so it never reacts to in_stall
  task automatic send_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    in_last <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // register write without lowering valid, so writes go back to back
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic program_regs(input logic [15:0] cap, input logic [15:0] dq,
                              input logic [15:0] bs, input logic [15:0] sq);
    write_reg(gss_pkg::REG_OUT_CAPACITY, cap);
    write_reg(gss_pkg::REG_DQUOTE_CODE, dq);
    write_reg(gss_pkg::REG_BACKSLASH_CODE, bs);
    write_reg(gss_pkg::REG_SQUOTE_CODE, sq);
    cfg_valid <= 1'b0;
  endtask

  // sender holds off until every predicted result has been delivered, then
  // lets the pipeline settle since lead bytes leave nothing to wait for
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one string of ntok tokens; the last token carries in_last on its last byte
  task automatic send_string(input int ntok);
    int sel;
    int pick;
    logic fin;
    logic [7:0] lb;
    logic [7:0] tb;
    for (int t = 0; t < ntok; t++) begin
      fin = (t == ntok - 1);
      sel = $urandom_range(99);
      pick = $urandom_range(9);
      lb = 8'($urandom_range(8'hFE, 8'h81));
      if (sel < 30) begin
        // plain printable ascii
        send_byte(8'($urandom_range(8'h7E, 8'h20)), fin);
      end else if (sel < 40) begin
        // one of the three escaped characters
        if (pick < 3) send_byte(gss_pkg::CH_DQUOTE, fin);
        else if (pick < 6) send_byte(gss_pkg::CH_BSLASH, fin);
        else send_byte(gss_pkg::CH_SQUOTE, fin);
      end else if (sel < 65) begin
        // well-formed double-byte character
        if (pick < 5) tb = 8'($urandom_range(8'h7E, 8'h40));
        else tb = 8'($urandom_range(8'hFE, 8'h80));
        send_byte(lb, 1'b0);
        send_byte(tb, fin);
      end else if (sel < 75) begin
        // lead followed by a byte that cannot be a trail
        if (pick < 8) tb = 8'($urandom_range(8'h3F, 8'h00));
        else if (pick == 8) tb = 8'h7F;
        else tb = 8'hFF;
        send_byte(lb, 1'b0);
        send_byte(tb, fin);
      end else if (sel < 85) begin
        // control and non-ascii single bytes that are not leads
        if (pick < 7) tb = 8'($urandom_range(8'h1F, 8'h00));
        else if (pick == 7) tb = 8'h7F;
        else if (pick == 8) tb = 8'h80;
        else tb = 8'hFF;
        send_byte(tb, fin);
      end else if (sel < 95) begin
        // raw noise
        send_byte(8'($urandom_range(255)), fin);
      end else begin
        // lone lead; dropped when it ends the string
        send_byte(lb, fin);
      end
    end
  endtask

  task automatic run_phase(input int idle, input int stall, input int quota,
                           input logic [15:0] cap, input logic [15:0] dq,
                           input logic [15:0] bs, input logic [15:0] sq);
    int start;
    program_regs(cap, dq, bs, sq);
    gap_pct = idle;
    stall_pct <= stall;
    start = items_sent;
    while (items_sent - start < quota) begin
      if ($urandom_range(9) == 0) send_string($urandom_range(40, 9));
      else send_string($urandom_range(8, 1));
    end
    drain();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: reset codes, maximum capacity of 65535, no idling
    send_byte("A", 1'b0);
    send_byte(gss_pkg::CH_SPACE, 1'b0);
    send_byte(gss_pkg::CH_TILDE, 1'b0);
    send_byte(gss_pkg::CH_NUL, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(gss_pkg::CH_DQUOTE, 1'b0);
    send_byte(gss_pkg::CH_BSLASH, 1'b0);
    send_byte(gss_pkg::CH_SQUOTE, 1'b0);
    // lowest lead with lowest trail, highest lead with highest trail
    send_byte(8'h81, 1'b0);
    send_byte(8'h40, 1'b0);
    send_byte(8'hFE, 1'b0);
    send_byte(8'hFE, 1'b0);
    // broken pairs: space for the lead, then the byte handled on its own
    send_byte(8'h81, 1'b0);
    send_byte(8'h3F, 1'b0);
    send_byte(8'hFE, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h90, 1'b0);
    send_byte(gss_pkg::CH_DQUOTE, 1'b0);
    // pending lead completed by a trail that ends the string
    send_byte(8'hA1, 1'b0);
    send_byte(8'h7E, 1'b1);
    // pending lead broken by the final byte
    send_byte(8'hB0, 1'b0);
    send_byte(8'h7F, 1'b1);
    // lead as the final byte is dropped
    send_byte(8'hC0, 1'b1);
    drain();

    // directed: capacity of three; the quote code straddles the limit and
    // everything after it is discarded up to the terminator
    program_regs(16'd3, gss_pkg::RST_DQUOTE_CODE, gss_pkg::RST_BACKSLASH_CODE,
                 gss_pkg::RST_SQUOTE_CODE);
    send_byte("a", 1'b0);
    send_byte("a", 1'b0);
    send_byte(gss_pkg::CH_DQUOTE, 1'b0);
    send_byte("b", 1'b0);
    send_byte(8'h81, 1'b0);
    send_byte(gss_pkg::CH_SQUOTE, 1'b1);
    drain();

    // random phases, each with its own register setting and idle mix
    run_phase(0, 0, 45, 16'hFFFF, 16'($urandom), 16'($urandom), 16'($urandom));
    run_phase(57, 0, 45, 16'd1, 16'h0000, 16'hFFFF, 16'($urandom));
    run_phase(0, 57, 45, 16'($urandom_range(12, 2)), 16'($urandom), 16'($urandom),
              16'($urandom));
    run_phase(9, 9, 45, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_phase(0, 0, 45, 16'($urandom_range(30, 3)), 16'($urandom), 16'($urandom),
              16'($urandom));
    run_phase(57, 0, 45, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000);
    run_phase(0, 57, 45, 16'd5, 16'($urandom), 16'($urandom), 16'($urandom));
    run_phase(9, 9, 45, 16'($urandom_range(20, 1)), 16'($urandom), 16'($urandom),
              16'($urandom));

    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/gss_pkg.sv
src/gss_queue.sv
src/gss_front.sv
src/gss_back.sv
src/gbk_string_sanitizer.sv
test/gss_checker.sv
test/tb_gbk_string_sanitizer.sv
